@@ rtl/grt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grt_pkg
// Shared types, constants and helper functions for the glyph text renderer.
// ----------------------------------------------------------------------------
package grt_pkg;

   // Field and datapath widths
   localparam int GSIZE_BITS     = 7;
   localparam int ROW_BITS       = 6;
   localparam int COORD_BITS     = 16;
   localparam int ADDR_BITS      = 32;
   localparam int CHAR_BITS      = 8;
   localparam int IDX_BITS       = 7;
   localparam int DIV_BITS       = 16;
   localparam int DIV_CNT_BITS   = 5;
   localparam int LINE_PROD_BITS = IDX_BITS + COORD_BITS;
   localparam int GLYPH_OFF_BITS = LINE_PROD_BITS + GSIZE_BITS;
   localparam int COL_OFF_BITS   = IDX_BITS + GSIZE_BITS;
   localparam int MAX_GLYPH_SIZE = 64;

   // Register file port
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;
   localparam int REG_IDX_BITS  = 3;

   localparam logic [REG_IDX_BITS-1:0] REG_GLYPH_SIZE       = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_FONT_SHEET_WIDTH = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_SCREEN_WIDTH     = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_FONT_BASE        = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_X         = 3'd4;
   localparam logic [REG_IDX_BITS-1:0] REG_ORIGIN_Y         = 3'd5;

   // Reset values
   localparam logic [GSIZE_BITS-1:0] RST_GLYPH_SIZE       = 7'd16;
   localparam logic [COORD_BITS-1:0] RST_FONT_SHEET_WIDTH = 16'd256;
   localparam logic [COORD_BITS-1:0] RST_SCREEN_WIDTH     = 16'd1024;
   localparam logic [ADDR_BITS-1:0]  RST_FONT_BASE        = 32'd0;
   localparam logic [COORD_BITS-1:0] RST_ORIGIN_X         = 16'd16;
   localparam logic [COORD_BITS-1:0] RST_ORIGIN_Y         = 16'd16;

   // Character codes
   localparam logic [CHAR_BITS-1:0] CHAR_NEWLINE     = 8'd10;
   localparam logic [CHAR_BITS-1:0] CHAR_FIRST_PRINT = 8'd32;
   localparam logic [CHAR_BITS-1:0] CHAR_LAST_PRINT  = 8'd126;
   localparam logic [IDX_BITS-1:0]  GLYPH_FALLBACK   = 7'd95;

   typedef struct packed {
      logic [GSIZE_BITS-1:0] glyph_size;
      logic [COORD_BITS-1:0] font_sheet_width;
      logic [COORD_BITS-1:0] screen_width;
      logic [ADDR_BITS-1:0]  font_base;
      logic [COORD_BITS-1:0] origin_x;
      logic [COORD_BITS-1:0] origin_y;
   } cfg_type;

   typedef struct packed {
      logic load_char;
      logic newline;
      logic div_sheet;
      logic div_glyph;
      logic mul_line;
      logic mul_glyph;
      logic sum_addr;
      logic emit_row;
      logic advance;
   } dp_cmd_type;

   typedef struct packed {
      logic is_newline;
      logic div_done;
      logic row_last;
      logic slot_free;
   } dp_status_type;

   // Clamp the glyph size into 1..MAX_GLYPH_SIZE
   function automatic logic [GSIZE_BITS-1:0] eff_size(input logic [GSIZE_BITS-1:0] size);
      logic [GSIZE_BITS-1:0] g;
      g = size;
      if (g == '0) begin
         g = GSIZE_BITS'(1);
      end
      if (g > GSIZE_BITS'(MAX_GLYPH_SIZE)) begin
         g = GSIZE_BITS'(MAX_GLYPH_SIZE);
      end
      return g;
   endfunction

   // Map a character byte to its glyph slot
   function automatic logic [IDX_BITS-1:0] glyph_index(input logic [CHAR_BITS-1:0] ch);
      logic [CHAR_BITS-1:0] diff;
      diff = ch - CHAR_FIRST_PRINT;
      if (ch >= CHAR_FIRST_PRINT && ch <= CHAR_LAST_PRINT) begin
         return diff[IDX_BITS-1:0];
      end
      return GLYPH_FALLBACK;
   endfunction

endpackage : grt_pkg
`default_nettype wire

@@ rtl/grt_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grt_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module grt_regs import grt_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready,
   output cfg_type                       cfg
);

   cfg_type                 cfg_ff;
   cfg_type                 cfg_in;
   logic                    wr_en;
   logic [REG_IDX_BITS-1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[CSR_ADDR_BITS-1:2];

   // Decode the write transaction
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_GLYPH_SIZE:       cfg_in.glyph_size       = pwdata[GSIZE_BITS-1:0];
            REG_FONT_SHEET_WIDTH: cfg_in.font_sheet_width = pwdata[COORD_BITS-1:0];
            REG_SCREEN_WIDTH:     cfg_in.screen_width     = pwdata[COORD_BITS-1:0];
            REG_FONT_BASE:        cfg_in.font_base        = pwdata[ADDR_BITS-1:0];
            REG_ORIGIN_X:         cfg_in.origin_x         = pwdata[COORD_BITS-1:0];
            REG_ORIGIN_Y:         cfg_in.origin_y         = pwdata[COORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.glyph_size       <= RST_GLYPH_SIZE;
         cfg_ff.font_sheet_width <= RST_FONT_SHEET_WIDTH;
         cfg_ff.screen_width     <= RST_SCREEN_WIDTH;
         cfg_ff.font_base        <= RST_FONT_BASE;
         cfg_ff.origin_x         <= RST_ORIGIN_X;
         cfg_ff.origin_y         <= RST_ORIGIN_Y;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Return the addressed register on a read
   always_comb begin
      unique case (reg_idx)
         REG_GLYPH_SIZE:       prdata = CSR_DATA_BITS'(cfg_ff.glyph_size);
         REG_FONT_SHEET_WIDTH: prdata = CSR_DATA_BITS'(cfg_ff.font_sheet_width);
         REG_SCREEN_WIDTH:     prdata = CSR_DATA_BITS'(cfg_ff.screen_width);
         REG_FONT_BASE:        prdata = CSR_DATA_BITS'(cfg_ff.font_base);
         REG_ORIGIN_X:         prdata = CSR_DATA_BITS'(cfg_ff.origin_x);
         REG_ORIGIN_Y:         prdata = CSR_DATA_BITS'(cfg_ff.origin_y);
         default:              prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule : grt_regs
`default_nettype wire

@@ rtl/grt_divider.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grt_divider
// Restoring divider, one quotient bit per cycle, run for a chosen step count.
// ----------------------------------------------------------------------------
module grt_divider import grt_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [DIV_BITS-1:0]     dividend,
   input  wire logic [DIV_BITS-1:0]     divisor,
   input  wire logic [DIV_CNT_BITS-1:0] steps,
   output logic      [DIV_BITS-1:0]     quotient,
   output logic      [DIV_BITS-1:0]     remainder,
   output logic                         done
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [DIV_CNT_BITS-1:0] count_ff, count_in;
   logic [DIV_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_BITS-1:0]     rem_ff, rem_in;
   logic [DIV_BITS-1:0]     div_ff, div_in;
   logic [DIV_BITS:0]       rem_shift;
   logic [DIV_BITS:0]       rem_diff;
   logic                    fits;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   assign rem_shift = {rem_ff, quo_ff[DIV_BITS-1]};
   assign fits      = rem_shift >= {1'b0, div_ff};
   assign rem_diff  = rem_shift - {1'b0, div_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = steps;
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         quo_in   = {quo_ff[DIV_BITS-2:0], fits};
         rem_in   = fits ? rem_diff[DIV_BITS-1:0] : rem_shift[DIV_BITS-1:0];
         count_in = count_ff - DIV_CNT_BITS'(1);
         if (count_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule : grt_divider
`default_nettype wire

@@ rtl/grt_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grt_datapath
// Glyph placement arithmetic, text cursor, row span generator and the
// output register of the result channel.
// ----------------------------------------------------------------------------
module grt_datapath import grt_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  cfg_type                    cfg,
   input  dp_cmd_type                 cmd,
   input  wire logic [CHAR_BITS-1:0]  req_char_code,
   input  wire logic                  rsp_stall,
   output dp_status_type              status,
   output logic                       rsp_valid,
   output logic      [ADDR_BITS-1:0]  rsp_font_addr,
   output logic      [COORD_BITS-1:0] rsp_screen_x,
   output logic      [COORD_BITS-1:0] rsp_screen_y,
   output logic      [GSIZE_BITS-1:0] rsp_span_len,
   output logic                       rsp_last_row
);

   logic [GSIZE_BITS-1:0]     g;
   logic [GSIZE_BITS-1:0]     g_minus_one;

   logic [IDX_BITS-1:0]       idx_ff, idx_in;
   logic [LINE_PROD_BITS-1:0] line_prod_ff, line_prod_in;
   logic [IDX_BITS-1:0]       col_ff, col_in;
   logic [GLYPH_OFF_BITS-1:0] glyph_off_ff, glyph_off_in;
   logic [COL_OFF_BITS-1:0]   col_off_ff, col_off_in;
   logic [ADDR_BITS-1:0]      addr_ff, addr_in;
   logic [COORD_BITS-1:0]     ycur_ff, ycur_in;
   logic [ROW_BITS-1:0]       row_ff, row_in;
   logic [COORD_BITS-1:0]     cursor_x_ff, cursor_x_in;
   logic [COORD_BITS-1:0]     cursor_y_ff, cursor_y_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ADDR_BITS-1:0]      rsp_font_addr_ff, rsp_font_addr_in;
   logic [COORD_BITS-1:0]     rsp_screen_x_ff, rsp_screen_x_in;
   logic [COORD_BITS-1:0]     rsp_screen_y_ff, rsp_screen_y_in;
   logic [GSIZE_BITS-1:0]     rsp_span_len_ff, rsp_span_len_in;
   logic                      rsp_last_row_ff, rsp_last_row_in;

   logic                      div_start;
   logic [DIV_BITS-1:0]       div_dividend;
   logic [DIV_BITS-1:0]       div_divisor;
   logic [DIV_CNT_BITS-1:0]   div_steps;
   logic [DIV_BITS-1:0]       div_quotient;
   logic [DIV_BITS-1:0]       div_remainder;
   logic                      div_done;
   logic [DIV_BITS-1:0]       per_line;

   logic [COORD_BITS-1:0]     next_x;
   logic [COORD_BITS:0]       wrap_sum;
   logic                      wrap;
   logic                      row_last;

   assign g           = eff_size(cfg.glyph_size);
   assign g_minus_one = g - GSIZE_BITS'(1);
   assign row_last    = row_ff == g_minus_one[ROW_BITS-1:0];

   // Shared divider: first glyphs per sheet line, then line and column
   assign per_line     = (div_quotient == '0) ? DIV_BITS'(1) : div_quotient;
   assign div_start    = cmd.div_sheet | cmd.div_glyph;
   assign div_dividend = cmd.div_glyph ? {idx_ff, (DIV_BITS-IDX_BITS)'(0)}
                                       : cfg.font_sheet_width;
   assign div_divisor  = cmd.div_glyph ? per_line : DIV_BITS'(g);
   assign div_steps    = cmd.div_glyph ? DIV_CNT_BITS'(IDX_BITS) : DIV_CNT_BITS'(DIV_BITS);

   grt_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .steps     (div_steps),
      .quotient  (div_quotient),
      .remainder (div_remainder),
      .done      (div_done)
   );

   // Cursor advance and wrap test, sum taken one bit wider
   assign next_x   = cursor_x_ff + COORD_BITS'(g);
   assign wrap_sum = {1'b0, next_x} + (COORD_BITS+1)'(g);
   assign wrap     = wrap_sum > {1'b0, cfg.screen_width};

   always_comb begin
      idx_in       = idx_ff;
      line_prod_in = line_prod_ff;
      col_in       = col_ff;
      glyph_off_in = glyph_off_ff;
      col_off_in   = col_off_ff;
      addr_in      = addr_ff;
      ycur_in      = ycur_ff;
      row_in       = row_ff;
      cursor_x_in  = cursor_x_ff;
      cursor_y_in  = cursor_y_ff;

      if (cmd.load_char) begin
         idx_in = glyph_index(req_char_code);
      end
      // Sheet line times sheet width, then times glyph size
      if (cmd.mul_line) begin
         line_prod_in = LINE_PROD_BITS'(div_quotient[IDX_BITS-1:0])
                      * LINE_PROD_BITS'(cfg.font_sheet_width);
         col_in       = div_remainder[IDX_BITS-1:0];
      end
      if (cmd.mul_glyph) begin
         glyph_off_in = GLYPH_OFF_BITS'(line_prod_ff) * GLYPH_OFF_BITS'(g);
         col_off_in   = COL_OFF_BITS'(col_ff) * COL_OFF_BITS'(g);
      end
      // Glyph start address and first row
      if (cmd.sum_addr) begin
         addr_in = cfg.font_base + ADDR_BITS'(glyph_off_ff) + ADDR_BITS'(col_off_ff);
         ycur_in = cursor_y_ff;
         row_in  = '0;
      end
      // Step to the next glyph row
      if (cmd.emit_row) begin
         addr_in = addr_ff + ADDR_BITS'(cfg.font_sheet_width);
         ycur_in = ycur_ff + COORD_BITS'(1);
         row_in  = row_ff + ROW_BITS'(1);
      end
      if (cmd.newline) begin
         cursor_x_in = cfg.origin_x;
         cursor_y_in = cursor_y_ff + COORD_BITS'(g);
      end
      if (cmd.advance) begin
         if (wrap) begin
            cursor_x_in = cfg.origin_x;
            cursor_y_in = cursor_y_ff + COORD_BITS'(g);
         end else begin
            cursor_x_in = next_x;
         end
      end
   end

   // Output register: load a span, hold it while stalled
   always_comb begin
      rsp_valid_in     = rsp_valid_ff & rsp_stall;
      rsp_font_addr_in = rsp_font_addr_ff;
      rsp_screen_x_in  = rsp_screen_x_ff;
      rsp_screen_y_in  = rsp_screen_y_ff;
      rsp_span_len_in  = rsp_span_len_ff;
      rsp_last_row_in  = rsp_last_row_ff;
      if (cmd.emit_row) begin
         rsp_valid_in     = 1'b1;
         rsp_font_addr_in = addr_ff;
         rsp_screen_x_in  = cursor_x_ff;
         rsp_screen_y_in  = ycur_ff;
         rsp_span_len_in  = g;
         rsp_last_row_in  = row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= RST_ORIGIN_X;
         cursor_y_ff  <= RST_ORIGIN_Y;
         rsp_valid_ff <= 1'b0;
      end else begin
         cursor_x_ff  <= cursor_x_in;
         cursor_y_ff  <= cursor_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff           <= idx_in;
      line_prod_ff     <= line_prod_in;
      col_ff           <= col_in;
      glyph_off_ff     <= glyph_off_in;
      col_off_ff       <= col_off_in;
      addr_ff          <= addr_in;
      ycur_ff          <= ycur_in;
      row_ff           <= row_in;
      rsp_font_addr_ff <= rsp_font_addr_in;
      rsp_screen_x_ff  <= rsp_screen_x_in;
      rsp_screen_y_ff  <= rsp_screen_y_in;
      rsp_span_len_ff  <= rsp_span_len_in;
      rsp_last_row_ff  <= rsp_last_row_in;
   end

   assign status.is_newline = req_char_code == CHAR_NEWLINE;
   assign status.div_done   = div_done;
   assign status.row_last   = row_last;
   assign status.slot_free  = ~rsp_valid_ff | ~rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_font_addr = rsp_font_addr_ff;
   assign rsp_screen_x  = rsp_screen_x_ff;
   assign rsp_screen_y  = rsp_screen_y_ff;
   assign rsp_span_len  = rsp_span_len_ff;
   assign rsp_last_row  = rsp_last_row_ff;

endmodule : grt_datapath
`default_nettype wire

@@ rtl/grt_controller.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grt_controller
// Sequencer for one character: divide, multiply, sum, emit rows, advance.
// ----------------------------------------------------------------------------
module grt_controller import grt_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_DIV_SHEET = 3'd1;
   localparam logic [2:0] S_DIV_GLYPH = 3'd2;
   localparam logic [2:0] S_MUL_GLYPH = 3'd3;
   localparam logic [2:0] S_SUM       = 3'd4;
   localparam logic [2:0] S_EMIT      = 3'd5;
   localparam logic [2:0] S_ADVANCE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_stall = state_ff != S_IDLE;
   assign accept    = req_valid & ~req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         // Take a transaction; a newline only moves the cursor
         S_IDLE: begin
            if (accept) begin
               if (status.is_newline) begin
                  cmd.newline = 1'b1;
               end else begin
                  cmd.load_char = 1'b1;
                  cmd.div_sheet = 1'b1;
                  state_in      = S_DIV_SHEET;
               end
            end
         end
         S_DIV_SHEET: begin
            if (status.div_done) begin
               cmd.div_glyph = 1'b1;
               state_in      = S_DIV_GLYPH;
            end
         end
         S_DIV_GLYPH: begin
            if (status.div_done) begin
               cmd.mul_line = 1'b1;
               state_in     = S_MUL_GLYPH;
            end
         end
         S_MUL_GLYPH: begin
            cmd.mul_glyph = 1'b1;
            state_in      = S_SUM;
         end
         S_SUM: begin
            cmd.sum_addr = 1'b1;
            state_in     = S_EMIT;
         end
         // Hand one row to the output register whenever it can take it
         S_EMIT: begin
            if (status.slot_free) begin
               cmd.emit_row = 1'b1;
               if (status.row_last) begin
                  state_in = S_ADVANCE;
               end
            end
         end
         S_ADVANCE: begin
            cmd.advance = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : grt_controller
`default_nettype wire

@@ rtl/glyph_text_renderer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_text_renderer
// Bitmap font character generator with a text cursor: one character in,
// one font-sheet span per glyph row out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  req_*     in         req_valid/req_stall   char_code
//  rsp_*     out        rsp_valid/rsp_stall   font_addr, screen_x/y, span_len, last_row
//  APB       in/out     psel/penable/pready   six registers at 4*index
//
//  A newline only moves the cursor. Any other character passes through the
//  glyphs-per-line division and the line/column division in the shared
//  one-bit-per-cycle divider, then multiply and sum, one span per glyph row
//  and the cursor advance.
//  Reset is synchronous; it sets the cursor to 16,16 and the registers to
//  their reset values.
//  A stalled result holds in the output register while the next character
//  can already be accepted; row emission waits for the register to free.
// ----------------------------------------------------------------------------
module glyph_text_renderer import grt_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [CHAR_BITS-1:0]     req_char_code,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic      [ADDR_BITS-1:0]     rsp_font_addr,
   output logic      [COORD_BITS-1:0]    rsp_screen_x,
   output logic      [COORD_BITS-1:0]    rsp_screen_y,
   output logic      [GSIZE_BITS-1:0]    rsp_span_len,
   output logic                          rsp_last_row,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic      [CSR_DATA_BITS-1:0] prdata,
   output logic                          pready
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   grt_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   grt_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   grt_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .req_char_code (req_char_code),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_font_addr (rsp_font_addr),
      .rsp_screen_x  (rsp_screen_x),
      .rsp_screen_y  (rsp_screen_y),
      .rsp_span_len  (rsp_span_len),
      .rsp_last_row  (rsp_last_row)
   );

endmodule : glyph_text_renderer
`default_nettype wire

@@ rtl/grt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grt_checker
// Port-level checks on the glyph text renderer, bound to the top level.
// ----------------------------------------------------------------------------
module grt_checker import grt_pkg::*; (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic [CHAR_BITS-1:0]     req_char_code,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire logic [ADDR_BITS-1:0]     rsp_font_addr,
   input wire logic [COORD_BITS-1:0]    rsp_screen_x,
   input wire logic [COORD_BITS-1:0]    rsp_screen_y,
   input wire logic [GSIZE_BITS-1:0]    rsp_span_len,
   input wire logic                     rsp_last_row,
   input wire logic                     pready
);

   // Hold a stalled result transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_font_addr)
         && $stable(rsp_screen_y) && $stable(rsp_last_row))
      else $error("stalled result changed");

   // Span length stays within the clamped glyph size
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_span_len != '0 && rsp_span_len <= GSIZE_BITS'(MAX_GLYPH_SIZE))
      else $error("span length out of range");

   // Rows of one glyph go down one screen row at a time in the same column
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row ##1 rsp_valid
         |-> rsp_screen_y == $past(rsp_screen_y) + COORD_BITS'(1)
             && rsp_screen_x == $past(rsp_screen_x)
             && rsp_span_len == $past(rsp_span_len))
      else $error("row sequence broken");

   // A drawn character blocks the input while its rows are prepared
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_char_code != CHAR_NEWLINE |=> req_stall)
      else $error("character taken while busy");

   // The register port never waits
   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready dropped");

endmodule : grt_checker

bind glyph_text_renderer grt_checker u_grt_checker (.*);
`default_nettype wire
